@@ src/bertlh_pkg.sv @@
package bertlh_pkg;

	localparam int HEADER_BYTES_DEF = 16;

	localparam int TAG_W = 64;
	localparam int LEN_W = 64;
	localparam int HLEN_W = 5;
	localparam int LEFT_W = 7;
	localparam int STATUS_W = 3;

	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 144;
	localparam int M_TUSER_W = STATUS_W;

	localparam logic [7:0] CLASS_MASK = 8'hc0;
	localparam logic [7:0] CONS_MASK = 8'h20;
	localparam logic [7:0] LOW_TAG_MASK = 8'h1f;
	localparam logic [7:0] MORE_MASK = 8'h80;
	localparam logic [7:0] LEN_INDEF = 8'h80;
	localparam logic [7:0] LEN_FORBID = 8'hff;
	localparam logic [7:0] GROUP_MASK = 8'h7f;

	typedef enum logic [1:0] {
		PH_IDENT,
		PH_TAGMORE,
		PH_LENOCT,
		PH_LENMORE
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_END       = 3'd1,
		ST_READERR   = 3'd2,
		ST_PREMATURE = 3'd3,
		ST_TOOLARGE  = 3'd4,
		ST_FORBIDDEN = 3'd5
	} status_t;

endpackage

@@ src/ber_tag_length_header_parser_core.sv @@
// BER identifier and length header parser.
// Input stream: one transaction per byte on s_axis. tdata carries the byte,
// tuser[0] marks end of stream (byte ignored) and tuser[1] says the reader
// failed rather than reaching a plain end.
// Output stream: one transaction per finished header, stream end or error on m_axis.
// tuser carries the status code; tdata carries class, constructed flag,
// tag number, content length, indefinite and non-DER flags and header length.
// A byte is taken into the input register, and its result, if any, is then
// registered in the output register.
// Throughput: one byte per cycle while no result waits on a full output,
// set by the combinational state update between the input and output registers.
// A byte that produces no result always moves on; one that produces a result
// waits in the input register only while the output register is full and
// m_axis_tready is low, and s_axis_tready falls only in that case.
// Reset clears both register valid flags and puts the parser at the
// identifier octet with all accumulators at zero. After every result the
// parser restarts at the identifier octet.
module ber_tag_length_header_parser_core
	import bertlh_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // in_byte[7:0]
	input  logic [S_TUSER_W-1:0] s_axis_tuser,  // stream_end, read_failed
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// tag_class[1:0], constructed, tag_number[63:0], content_length[63:0],
	// indefinite, not_der, header_length[4:0], zero fill[5:0]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic [M_TUSER_W-1:0] m_axis_tuser   // status[2:0]
);

	localparam int BW = $clog2(HEADER_BYTES + 1);
	localparam logic [BW-1:0] HB = BW'(HEADER_BYTES);
	localparam int PAD_W = M_TDATA_W - (2 + 1 + TAG_W + LEN_W + 1 + 1 + HLEN_W);

	// input register
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                fail_s1;

	// parser state
	phase_t              phase_q, phase_d;
	logic [BW-1:0]       cnt_q, cnt_d, cnt_inc;
	logic [1:0]          class_q, class_d;
	logic                cons_q, cons_d;
	logic [TAG_W-1:0]    tag_q, tag_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [LEFT_W-1:0]   left_q, left_d, left_dec;
	logic [LEN_W-1:0]    len_shift;

	// result
	logic                res_valid;
	logic                restart;
	status_t             res_status;
	logic [1:0]          res_class;
	logic                res_cons;
	logic [TAG_W-1:0]    res_tag;
	logic [LEN_W-1:0]    res_len;
	logic                res_indef;
	logic [BW-1:0]       res_cnt;
	logic [BW+HLEN_W-1:0] res_cnt_ext;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [1:0]          out_class_q;
	logic                out_cons_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [LEN_W-1:0]    out_len_q;
	logic                out_indef_q;
	logic [HLEN_W-1:0]   out_hlen_q;

	logic                adv;

	assign adv = valid_s1 && (!res_valid || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	assign cnt_inc = cnt_q + BW'(1);
	assign left_dec = (left_q != '0) ? left_q - LEFT_W'(1) : left_q;
	assign len_shift = {len_q[LEN_W-9:0], byte_s1};

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		class_d = class_q;
		cons_d = cons_q;
		tag_d = tag_q;
		len_d = len_q;
		left_d = left_q;
		res_valid = 1'b0;
		restart = 1'b0;
		res_status = ST_OK;
		res_class = '0;
		res_cons = 1'b0;
		res_tag = '0;
		res_len = '0;
		res_indef = 1'b0;
		res_cnt = cnt_q;
		if (end_s1) begin
			res_valid = 1'b1;
			restart = 1'b1;
			if (fail_s1) begin
				res_status = ST_READERR;
			end else if (phase_q == PH_IDENT) begin
				res_status = ST_END;
			end else begin
				res_status = ST_PREMATURE;
			end
		end else if (phase_q == PH_IDENT) begin
			cnt_d = BW'(1);
			class_d = byte_s1[7:6];
			cons_d = (byte_s1 & CONS_MASK) != 8'h00;
			if ((byte_s1 & LOW_TAG_MASK) == LOW_TAG_MASK) begin
				tag_d = '0;
				phase_d = PH_TAGMORE;
			end else begin
				tag_d = TAG_W'(byte_s1 & LOW_TAG_MASK);
				phase_d = PH_LENOCT;
			end
		end else if (cnt_q >= HB) begin
			res_valid = 1'b1;
			restart = 1'b1;
			res_status = ST_TOOLARGE;
		end else begin
			cnt_d = cnt_inc;
			res_cnt = cnt_inc;
			res_class = class_q;
			res_cons = cons_q;
			res_tag = tag_q;
			unique case (phase_q)
				PH_TAGMORE: begin
					tag_d = {tag_q[TAG_W-8:0], byte_s1[6:0]};
					if ((byte_s1 & MORE_MASK) == 8'h00) begin
						phase_d = PH_LENOCT;
					end
				end
				PH_LENOCT: begin
					if ((byte_s1 & MORE_MASK) == 8'h00) begin
						res_valid = 1'b1;
						restart = 1'b1;
						res_len = LEN_W'(byte_s1);
					end else if (byte_s1 == LEN_INDEF) begin
						res_valid = 1'b1;
						restart = 1'b1;
						res_indef = 1'b1;
					end else if (byte_s1 == LEN_FORBID) begin
						res_valid = 1'b1;
						restart = 1'b1;
						res_status = ST_FORBIDDEN;
					end else begin
						len_d = '0;
						left_d = LEFT_W'(byte_s1 & GROUP_MASK);
						phase_d = PH_LENMORE;
					end
				end
				PH_LENMORE: begin
					len_d = len_shift;
					left_d = left_dec;
					if (left_dec == '0) begin
						res_valid = 1'b1;
						restart = 1'b1;
						res_len = len_shift;
					end
				end
				default: begin
					phase_d = PH_IDENT;
				end
			endcase
			if (res_status != ST_OK) begin
				res_class = '0;
				res_cons = 1'b0;
				res_tag = '0;
			end
			if (res_class == 2'd0 && res_tag == '0) begin
				res_len = '0;
			end
		end
		if (restart) begin
			phase_d = PH_IDENT;
			cnt_d = '0;
			class_d = '0;
			cons_d = 1'b0;
			tag_d = '0;
			len_d = '0;
			left_d = '0;
		end
	end

	assign res_cnt_ext = {{HLEN_W{1'b0}}, res_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1 <= s_axis_tuser[0];
			fail_s1 <= s_axis_tuser[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDENT;
			cnt_q <= '0;
			class_q <= '0;
			cons_q <= 1'b0;
			tag_q <= '0;
			len_q <= '0;
			left_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			class_q <= class_d;
			cons_q <= cons_d;
			tag_q <= tag_d;
			len_q <= len_d;
			left_q <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_status_q <= res_status;
			out_class_q <= res_class;
			out_cons_q <= res_cons;
			out_tag_q <= res_tag;
			out_len_q <= res_len;
			out_indef_q <= res_indef;
			out_hlen_q <= res_cnt_ext[HLEN_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_status_q;
	assign m_axis_tdata = {{PAD_W{1'b0}}, out_hlen_q, out_indef_q, out_indef_q,
		out_len_q, out_tag_q, out_cons_q, out_class_q};

	a_ident_count_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDENT) |-> (cnt_q == '0))
		else $error("byte count not cleared at identifier octet");

	a_count_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HB)
		else $error("header byte count beyond buffer size");

	a_lenmore_left : assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LENMORE) |-> (left_q != '0))
		else $error("long-form length phase with no bytes left");

	a_error_fields_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |->
		(out_tag_q == '0 && out_class_q == '0 && out_len_q == '0 && !out_indef_q))
		else $error("error result carries header fields");

	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted transaction lost from input register");

endmodule

@@ verif/ber_tag_length_header_parser_core_tb.sv @@
`timescale 1ns / 100ps

module ber_tag_length_header_parser_core_tb;
	import bertlh_pkg::*;

	localparam int HEADER_BYTES = HEADER_BYTES_DEF;

	typedef struct {
		status_t           status;
		logic [1:0]        tag_class;
		logic              constructed;
		logic [TAG_W-1:0]  tag_number;
		logic [LEN_W-1:0]  content_length;
		logic              indefinite;
		logic              not_der;
		logic [HLEN_W-1:0] header_length;
	} ber_header_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;

	ber_header_t pending_headers[$];
	int unsigned mismatch_count = 0;
	int unsigned bytes_sent = 0;
	logic        tx_idle_en = 1'b1;
	logic        rx_idle_en = 1'b1;
	int unsigned rx_hold = 0;

	phase_t            parse_phase;
	int unsigned       parse_taken;
	logic [1:0]        parse_class;
	logic              parse_cons;
	logic [TAG_W-1:0]  parse_tag;
	logic [LEN_W-1:0]  parse_len;
	logic [LEFT_W-1:0] parse_len_left;

	ber_tag_length_header_parser_core #(
		.HEADER_BYTES(HEADER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("FAIL ber_tag_length_header_parser_core");
		$finish;
	end

	task automatic restart_parse();
		parse_phase = PH_IDENT;
		parse_taken = 0;
		parse_class = '0;
		parse_cons = 1'b0;
		parse_tag = '0;
		parse_len = '0;
		parse_len_left = '0;
	endtask

	task automatic push_error(input status_t status, input int unsigned hlen);
		ber_header_t h;
		h = '{status: status, tag_class: '0, constructed: 1'b0, tag_number: '0,
			content_length: '0, indefinite: 1'b0, not_der: 1'b0,
			header_length: hlen[HLEN_W-1:0]};
		pending_headers.push_back(h);
		restart_parse();
	endtask

	task automatic push_header(input logic [LEN_W-1:0] len, input logic indef);
		ber_header_t h;
		// universal class with tag zero reports no content
		if (parse_class == 2'd0 && parse_tag == '0) begin
			len = '0;
		end
		h = '{status: ST_OK, tag_class: parse_class, constructed: parse_cons,
			tag_number: parse_tag, content_length: len, indefinite: indef,
			not_der: indef, header_length: parse_taken[HLEN_W-1:0]};
		pending_headers.push_back(h);
		restart_parse();
	endtask

	task automatic parse_ber_byte(input logic [7:0] b, input logic stream_end,
			input logic read_failed);
		if (stream_end) begin
			if (read_failed) begin
				push_error(ST_READERR, parse_taken);
			end else if (parse_phase == PH_IDENT) begin
				push_error(ST_END, parse_taken);
			end else begin
				push_error(ST_PREMATURE, parse_taken);
			end
		end else if (parse_phase == PH_IDENT) begin
			parse_taken = 1;
			parse_class = 2'((b & CLASS_MASK) >> 6);
			parse_cons = (b & CONS_MASK) != 8'h00;
			if ((b & LOW_TAG_MASK) == LOW_TAG_MASK) begin
				parse_tag = '0;
				parse_phase = PH_TAGMORE;
			end else begin
				parse_tag = TAG_W'(b & LOW_TAG_MASK);
				parse_phase = PH_LENOCT;
			end
		end else if (parse_taken >= HEADER_BYTES) begin
			push_error(ST_TOOLARGE, parse_taken);
		end else begin
			parse_taken++;
			case (parse_phase)
				PH_TAGMORE: begin
					parse_tag = (parse_tag << 7) | TAG_W'(b & GROUP_MASK);
					if ((b & MORE_MASK) == 8'h00) begin
						parse_phase = PH_LENOCT;
					end
				end
				PH_LENOCT: begin
					if ((b & MORE_MASK) == 8'h00) begin
						push_header(LEN_W'(b), 1'b0);
					end else if (b == LEN_INDEF) begin
						push_header('0, 1'b1);
					end else if (b == LEN_FORBID) begin
						push_error(ST_FORBIDDEN, parse_taken);
					end else begin
						parse_len = '0;
						parse_len_left = LEFT_W'(b & GROUP_MASK);
						parse_phase = PH_LENMORE;
					end
				end
				default: begin
					parse_len = (parse_len << 8) | LEN_W'(b);
					if (parse_len_left > 0) begin
						parse_len_left--;
					end
					if (parse_len_left == 0) begin
						push_header(parse_len, 1'b0);
					end
				end
			endcase
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic stream_end,
			input logic read_failed);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= {read_failed, stream_end};
		do @(posedge clk); while (!s_axis_tready);
		parse_ber_byte(b, stream_end, read_failed);
		bytes_sent++;
	endtask

	task automatic send_header();
		logic [7:0]  hdr[$];
		logic [7:0]  ident;
		logic [7:0]  g;
		int unsigned groups;
		int unsigned nlen;
		int unsigned kind;
		int unsigned cut;
		ident = 8'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			ident = ident & CONS_MASK;
		end else if ($urandom_range(0, 2) == 0) begin
			ident = ident | LOW_TAG_MASK;
		end
		hdr.push_back(ident);
		if ((ident & LOW_TAG_MASK) == LOW_TAG_MASK) begin
			groups = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 3);
			for (int unsigned i = 0; i < groups; i++) begin
				g = 8'($urandom) & GROUP_MASK;
				if (i != groups - 1) begin
					g = g | MORE_MASK;
				end
				hdr.push_back(g);
			end
		end
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			hdr.push_back(8'($urandom_range(0, 127)));
		end else if (kind == 4) begin
			hdr.push_back(LEN_INDEF);
		end else if (kind == 5) begin
			hdr.push_back(LEN_FORBID);
		end else begin
			case ($urandom_range(0, 15))
				0: nlen = $urandom_range(15, 126);
				1, 2: nlen = $urandom_range(9, 14);
				default: nlen = $urandom_range(1, 8);
			endcase
			hdr.push_back(MORE_MASK | 8'(nlen));
			repeat (nlen) hdr.push_back(8'($urandom));
		end
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, hdr.size() - 1) : hdr.size();
		for (int unsigned i = 0; i < cut; i++) begin
			send_byte(hdr[i], 1'b0, $urandom_range(0, 15) == 0);
		end
		if (cut < hdr.size()) begin
			send_byte(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_directed_cases();
		// clean end and read error at the identifier
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b1, 1'b1);
		// universal tag zero forces length to zero
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h05, 1'b0, 1'b0);
		// high tag, indefinite length
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h7f, 1'b0, 1'b0);
		send_byte(LEN_INDEF, 1'b0, 1'b0);
		// forbidden length
		send_byte(8'h1e, 1'b0, 1'b0);
		send_byte(LEN_FORBID, 1'b0, 1'b0);
		// long form, one length byte
		send_byte(8'h42, 1'b0, 1'b0);
		send_byte(8'h81, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		// premature end inside the tag
		send_byte(8'h9f, 1'b0, 1'b0);
		send_byte(8'h81, 1'b0, 1'b0);
		send_byte(8'h5a, 1'b1, 1'b0);
		// reader error flag on a byte is ignored
		send_byte(8'h30, 1'b0, 1'b1);
		send_byte(8'h7f, 1'b0, 1'b1);
		// reader error inside a header
		send_byte(8'h02, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b1, 1'b1);
	endtask

	task automatic test_random_headers(input int unsigned n);
		int unsigned stop_at;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) begin
			send_header();
			if ($urandom_range(0, 9) == 0) begin
				send_byte(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_noise(input int unsigned n);
		repeat (n) begin
			send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_drain_between_headers();
		repeat (6) begin
			send_header();
			// hold off until every pending header has come out
			s_axis_tvalid <= 1'b0;
			wait (pending_headers.size() == 0);
			@(posedge clk);
		end
	endtask

	task automatic test_steady_stream(input int unsigned n);
		tx_idle_en = 1'b0;
		rx_idle_en <= 1'b0;
		test_random_headers(n);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	always @(posedge clk) begin : result_check
		ber_header_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_headers.size() == 0) begin
				report_mismatch("unrequested transaction", 64'(m_axis_tuser), '0);
			end else begin
				want = pending_headers.pop_front();
				check_field("status", 64'(m_axis_tuser), 64'(want.status));
				check_field("tag_class", 64'(m_axis_tdata[1:0]), 64'(want.tag_class));
				check_field("constructed", 64'(m_axis_tdata[2]), 64'(want.constructed));
				check_field("tag_number", m_axis_tdata[66:3], want.tag_number);
				check_field("content_length", m_axis_tdata[130:67], want.content_length);
				check_field("indefinite", 64'(m_axis_tdata[131]), 64'(want.indefinite));
				check_field("not_der", 64'(m_axis_tdata[132]), 64'(want.not_der));
				check_field("header_length", 64'(m_axis_tdata[137:133]),
					64'(want.header_length));
				check_field("zero fill", 64'(m_axis_tdata[143:138]), '0);
			end
		end
		if (!rx_idle_en) begin
			m_axis_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= $urandom_range(0, 5);
		end else begin
			m_axis_tready <= 1'b1;
			rx_hold <= $urandom_range(0, 8);
		end
	end

	initial begin
		restart_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_headers(600);
		test_noise(250);
		test_drain_between_headers();
		test_steady_stream(150);
		s_axis_tvalid <= 1'b0;
		wait (pending_headers.size() == 0);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS ber_tag_length_header_parser_core");
		end else begin
			$display("FAIL ber_tag_length_header_parser_core");
		end
		$finish;
	end

endmodule
